FILE: rtl/signed_int_to_decimal_chars_defines.svh
// Assertion macros shared by the decimal text converter modules.
`ifndef SIGNED_INT_TO_DECIMAL_CHARS_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_CHARS_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SITDC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SITDC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sitdc_pkg.sv
// Shared constants and helpers for the signed integer to decimal text converter.
package sitdc_pkg;

  localparam int IN_BITS   = 64;
  localparam int CHAR_BITS = 8;

  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'd45;
  localparam logic [CHAR_BITS-1:0] CHAR_NINE  = 8'd57;

  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ     = 4'd3;

  // Shift-and-add-3 correction of one BCD digit ahead of a left shift.
  function automatic logic [3:0] bcd_adjust(input logic [3:0] d);
    bcd_adjust = (d >= BCD_ADJ_MIN) ? d + BCD_ADJ : d;
  endfunction

endpackage

FILE: rtl/sitdc_ifs.sv
// Valid/ready channel interfaces for the input integer and output characters.
interface sitdc_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [sitdc_pkg::IN_BITS-1:0]    value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitdc_out_if;
  logic                                valid;
  logic                                ready;
  logic [sitdc_pkg::CHAR_BITS-1:0]     char_code;
  logic                                last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

FILE: rtl/sitdc_front.sv
// Front end: accepts integers, splits sign and magnitude, queues them two deep.
`include "signed_int_to_decimal_chars_defines.svh"

module sitdc_front #(
  parameter int VALUE_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  sitdc_in_if.sink              in_ch,
  output logic                  q_valid,
  output logic                  q_neg,
  output logic [VALUE_BITS-1:0] q_mag,
  input  logic                  q_pop
);

  localparam logic [1:0] DEPTH = 2'd2;

  logic [VALUE_BITS-1:0] v;
  logic                  neg;
  logic [VALUE_BITS-1:0] mag;
  logic                  push;

  logic                  neg_mem_r [2];
  logic [VALUE_BITS-1:0] mag_mem_r [2];
  logic                  wr_ptr_r, wr_ptr_nxt;
  logic                  rd_ptr_r, rd_ptr_nxt;
  logic [1:0]            count_r, count_nxt;

  assign v   = in_ch.value[VALUE_BITS-1:0];
  assign neg = v[VALUE_BITS-1];
  assign mag = neg ? (~v + 1'b1) : v;

  assign in_ch.ready = (count_r != DEPTH);
  assign push        = in_ch.valid & in_ch.ready;

  assign q_valid = (count_r != 2'd0);
  assign q_neg   = neg_mem_r[rd_ptr_r];
  assign q_mag   = mag_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      neg_mem_r[wr_ptr_r] <= neg;
      mag_mem_r[wr_ptr_r] <= mag;
    end
  end

  `SITDC_ASSERT_IMP(a_pop_nonempty, q_pop, count_r != 2'd0, "pop from empty queue")
  `SITDC_ASSERT_NXT(a_push_visible, (count_r == 2'd0) && push, q_valid, "pushed entry lost")

endmodule

FILE: rtl/sitdc_back.sv
// Back end: shift-and-add-3 conversion to BCD, then character emission.
`include "signed_int_to_decimal_chars_defines.svh"

module sitdc_back #(
  parameter int VALUE_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  logic                  q_neg,
  input  logic [VALUE_BITS-1:0] q_mag,
  output logic                  q_pop,
  sitdc_out_if.source           out_ch
);

  // Most digits of a magnitude up to 2^(VALUE_BITS-1).
  localparam int ND = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int BW = 4 * ND;
  localparam int CW = $clog2(VALUE_BITS);
  localparam int RW = $clog2(ND + 1);

  typedef enum logic [2:0] {S_IDLE, S_CONV, S_SKIP, S_SIGN, S_DIGIT} state_t;

  state_t                        state_r, state_nxt;
  logic [VALUE_BITS-1:0]         bin_r, bin_nxt;
  logic [BW-1:0]                 bcd_r, bcd_nxt;
  logic [BW-1:0]                 adj;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [RW-1:0]                 rem_r, rem_nxt;
  logic                          neg_r, neg_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [sitdc_pkg::CHAR_BITS-1:0] out_char_r, out_char_nxt;
  logic                          out_last_r, out_last_nxt;
  logic                          out_free;
  logic [3:0]                    top;

  assign out_free = !out_valid_r || out_ch.ready;
  assign top      = bcd_r[BW-1 -: 4];

  always_comb begin
    for (int i = 0; i < ND; i++) begin
      adj[4*i +: 4] = sitdc_pkg::bcd_adjust(bcd_r[4*i +: 4]);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          bin_nxt   = q_mag;
          neg_nxt   = q_neg;
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        bcd_nxt = {adj[BW-2:0], bin_r[VALUE_BITS-1]};
        bin_nxt = bin_r << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(VALUE_BITS - 1)) begin
          rem_nxt   = RW'(ND);
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        if (top == 4'd0 && rem_r != RW'(1)) begin
          bcd_nxt = bcd_r << 4;
          rem_nxt = rem_r - 1'b1;
        end else begin
          state_nxt = neg_r ? S_SIGN : S_DIGIT;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = sitdc_pkg::CHAR_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = sitdc_pkg::CHAR_ZERO + 8'(top);
          out_last_nxt  = (rem_r == RW'(1));
          bcd_nxt       = bcd_r << 4;
          rem_nxt       = rem_r - 1'b1;
          if (rem_r == RW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    cnt_r      <= cnt_nxt;
    rem_r      <= rem_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.char_code = out_char_r;
  assign out_ch.last      = out_last_r;

  `SITDC_ASSERT_IMP(a_char_legal, out_valid_r, (out_char_r == sitdc_pkg::CHAR_MINUS) || ((out_char_r >= sitdc_pkg::CHAR_ZERO) && (out_char_r <= sitdc_pkg::CHAR_NINE)), "illegal character code")
  `SITDC_ASSERT_IMP(a_sign_not_last, out_valid_r && (out_char_r == sitdc_pkg::CHAR_MINUS), !out_last_r, "sign flagged last")
  `SITDC_ASSERT_NXT(a_last_to_idle, (state_r == S_DIGIT) && out_free && (rem_r == RW'(1)), (state_r == S_IDLE) && out_last_r, "final digit not closing the transaction")

endmodule

FILE: rtl/signed_int_to_decimal_chars.sv
// Signed integer to decimal ASCII text: takes one integer per input transaction and
// emits its characters one per output transaction, most significant first, a '-'
// ahead of negative values, no leading zeros, last set on the final character.
// Only the low VALUE_BITS bits of value are used. Each item passes through the
// shift-and-add-3 loop, one magnitude bit per cycle, into a BCD register with room
// for the maximum digit count (19 at 64 bits), then through the one-character-a-
// cycle leading-zero skip and emit; the emit holds while the output is stalled. A
// two-deep queue keeps accepting while one item converts.
module signed_int_to_decimal_chars #(
  parameter int VALUE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  sitdc_in_if.sink    in_ch,
  sitdc_out_if.source out_ch
);

  logic                  q_valid;
  logic                  q_neg;
  logic [VALUE_BITS-1:0] q_mag;
  logic                  q_pop;

  sitdc_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_neg   (q_neg),
    .q_mag   (q_mag),
    .q_pop   (q_pop)
  );

  sitdc_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_neg   (q_neg),
    .q_mag   (q_mag),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

FILE: tb/tb_signed_int_to_decimal_chars.sv
// Testbench for signed_int_to_decimal_chars: predicts decimal text and checks each character.
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_chars;

  localparam int VALUE_BITS = 64;
  localparam int MAX_CHARS  = 20;

  typedef struct packed {
    logic [sitdc_pkg::CHAR_BITS-1:0] code;
    logic                            last;
  } dec_char_t;

  logic clk = 1'b0;
  logic rst_n;

  sitdc_in_if  in_ch ();
  sitdc_out_if out_ch ();

  signed_int_to_decimal_chars #(
    .VALUE_BITS(VALUE_BITS)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  dec_char_t expected_chars[$];
  int        mismatch_count = 0;
  int        src_idle_pct   = 0;
  int        snk_idle_pct   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [63:0] pow10(input int k);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < k; i++) p = p * 64'd10;
    return p;
  endfunction

  // Expected text of one number: optional '-', then digits, last on the final one.
  function automatic void predict_decimal_text(input logic [sitdc_pkg::IN_BITS-1:0] raw);
    logic [63:0] mask;
    logic [63:0] v;
    logic [63:0] mag;
    logic        neg;
    logic [3:0]  digs[MAX_CHARS];
    int          nd;
    dec_char_t   c;
    mask = {64{1'b1}} >> (64 - VALUE_BITS);
    v    = raw & mask;
    neg  = v[VALUE_BITS-1];
    mag  = neg ? ((~v + 64'd1) & mask) : v;
    nd   = 0;
    do begin
      if (nd < MAX_CHARS) begin
        digs[nd] = 4'(mag % 64'd10);
        nd++;
      end
      mag = mag / 64'd10;
    end while (mag != 64'd0);
    if (neg) begin
      c.code = sitdc_pkg::CHAR_MINUS;
      c.last = 1'b0;
      expected_chars.push_back(c);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      c.code = sitdc_pkg::CHAR_ZERO + 8'(digs[i]);
      c.last = (i == 0);
      expected_chars.push_back(c);
    end
  endfunction

  task automatic send_value(input logic [sitdc_pkg::IN_BITS-1:0] v);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_decimal_text(v);
  endtask

  task automatic wait_for_chars();
    in_ch.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  // Output side: check each transaction, then pick the next ready.
  always @(posedge clk) begin
    dec_char_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_chars.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected character: code %0d last %0b", out_ch.char_code, out_ch.last);
      end else begin
        want = expected_chars.pop_front();
        if (out_ch.char_code !== want.code || out_ch.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected code %0d last %0b, got code %0d last %0b",
                     want.code, want.last, out_ch.char_code, out_ch.last);
        end
      end
    end
    out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  task automatic test_directed();
    logic [63:0] vals[$];
    vals = '{64'd0, 64'd1, -64'sd1, 64'd9, 64'd10, -64'sd10, 64'd99, 64'd100,
             64'd1234567890, -64'sd9876543210, 64'h7FFF_FFFF_FFFF_FFFF,
             64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
             pow10(18), pow10(18) - 64'd1, -pow10(18), pow10(19),
             64'd1234567890123456789, -64'sd5555555555, 64'd4294967295,
             -64'sd4294967296, 64'hFFFF_FFFF_FFFF_FFFE};
    foreach (vals[i]) send_value(vals[i]);
  endtask

  function automatic logic [63:0] random_value();
    logic [63:0] m;
    case ($urandom_range(0, 5))
      0: m = {$urandom, $urandom};
      1: m = 64'($urandom_range(0, 999));
      2: m = pow10($urandom_range(0, 18)) + 64'($urandom_range(0, 2)) - 64'd1;
      3: m = {$urandom, $urandom} >> $urandom_range(0, 63);
      4: m = 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
      default: m = {1'b1, 31'($urandom), $urandom};
    endcase
    if ($urandom_range(0, 1)) m = -m;
    return m;
  endfunction

  task automatic test_random(input int n);
    repeat (n) send_value(random_value());
  endtask

  // Sender holds off until all text so far has come out, then resumes.
  task automatic test_drain_pause();
    repeat (3) send_value(random_value());
    wait_for_chars();
    repeat (3) send_value(random_value());
    wait_for_chars();
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.value  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_idle_pct = 31;
    snk_idle_pct = 82;
    test_directed();
    test_random(45);
    test_drain_pause();

    src_idle_pct = 82;
    snk_idle_pct = 31;
    test_random(45);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random(45);

    wait_for_chars();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
